FILE: rtl/integer_to_ascii_formatter_defines.svh
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter assertion macros
// shared property wrappers, clocked on clk_i and held off during reset
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// condition that must hold at every edge out of reset
`define I2A_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define I2A_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// request types, mode and state codes and character constants
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2a_pkg;

  typedef enum logic [2:0] {
    MODE_SDEC = 3'd0,
    MODE_UDEC = 3'd1,
    MODE_OCT  = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_PTR  = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV,
    S_SCAN,
    S_PFX0,
    S_PFXX,
    S_SIGN1,
    S_PAD,
    S_SIGN2,
    S_DIGIT
  } state_e;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  mode;
    logic [5:0]  width;
    logic        zero_pad;
  } in_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } out_t;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h61;
  localparam logic [6:0] CHAR_MINUS = 7'h2d;
  localparam logic [6:0] CHAR_X     = 7'h78;
  localparam logic [6:0] CHAR_SPACE = 7'h20;
  localparam logic [3:0] PTR_WIDTH  = 4'd8;

  // one digit value 0..15 to its lowercase ascii character
  function automatic logic [6:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + 7'(d);
    end else begin
      digit_char = CHAR_A + 7'(d) - 7'd10;
    end
  endfunction

endpackage

FILE: rtl/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// printf style integer conversion (signed/unsigned decimal, octal, hex,
// pointer) to a stream of ascii characters
// ----------------------------------------------------------------------------
// One request carries a word, a mode, a minimum field width and a zero-pad
// flag; the block answers with one character per output transfer and marks
// the final one with last_char. Modes 5 to 7 are taken and produce nothing.
// Steps of one request: conversion, in which the word is shifted in one bit
// per cycle, msb first, through a chain of 4-bit digit cells (add-3
// correction for decimal, plain shift for octal and hex); then a scan that
// drops leading zero digits (at most NDIG-1, NDIG being ceil(VALUE_BITS/3))
// and then sets the padding count; then one character per cycle while the
// sink is ready, with the sign and padding steps in between, which may emit
// nothing. A new request is taken once the previous one's last character
// sits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "integer_to_ascii_formatter_defines.svh"

module integer_to_ascii_formatter #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_WIDTH  = 60
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  i2a_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output i2a_pkg::out_t out_data_o
);

  import i2a_pkg::*;

  // digit cells: octal needs the most digits of the three radixes
  localparam int NDIG = (VALUE_BITS + 2) / 3;
  localparam int BW   = $clog2(VALUE_BITS);
  localparam int DW   = $clog2(NDIG + 1);
  localparam int PW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = ((PW > DW) ? PW : DW) + 1;

  // control state
  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // request and working registers
  out_t                     out_q, out_d;
  mode_e                    mode_q, mode_d;
  logic                     neg_q, neg_d;
  logic                     zpad_q, zpad_d;
  logic                     ptr_q, ptr_d;
  logic [PW-1:0]            w_q, w_d;
  logic [PW-1:0]            pad_q, pad_d;
  logic [VALUE_BITS-1:0]    mag_q, mag_d;
  logic [BW-1:0]            bcnt_q, bcnt_d;
  logic [DW-1:0]            dcnt_q, dcnt_d;
  logic [NDIG-1:0][3:0]     dig_q, dig_d;

  // digit chain next value
  logic [NDIG-1:0][2:0]     dig_keep;
  logic [NDIG-1:0]          dig_co;
  logic [NDIG-1:0][3:0]     dig_shift;

  // helpers
  logic                     out_free;
  logic                     mode_ok;
  logic [VALUE_BITS-1:0]    val_ext;
  logic                     val_neg;
  logic [5:0]               w_sat;
  logic [CW-1:0]            used;
  logic [CW-1:0]            w_ext;
  logic [PW-1:0]            pad_calc;

  assign out_free  = !out_valid_q || out_ready_i;
  assign mode_ok   = (in_data_i.mode <= MODE_PTR);
  assign val_ext   = VALUE_BITS'(in_data_i.value);
  assign val_neg   = (in_data_i.mode == MODE_SDEC) && val_ext[VALUE_BITS-1];
  assign w_sat     = (in_data_i.width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : in_data_i.width;

  // padding = field width minus digits minus sign, floored at zero
  assign used      = CW'(dcnt_q) + CW'(neg_q);
  assign w_ext     = CW'(w_q);
  assign pad_calc  = (w_ext > used) ? PW'(w_ext - used) : '0;

  // one cell per digit; each takes the carry of the cell below it
  always_comb begin
    logic [3:0] d;
    logic [3:0] adj;
    for (int i = 0; i < NDIG; i++) begin
      d   = dig_q[i];
      adj = d;
      case (mode_q) inside
        MODE_SDEC, MODE_UDEC: begin
          // add-3 correction keeps each cell a valid bcd digit after the shift
          adj         = (d >= 4'd5) ? d + 4'd3 : d;
          dig_co[i]   = adj[3];
          dig_keep[i] = adj[2:0];
        end
        MODE_OCT: begin
          dig_co[i]   = d[2];
          dig_keep[i] = {1'b0, d[1:0]};
        end
        default: begin
          dig_co[i]   = d[3];
          dig_keep[i] = d[2:0];
        end
      endcase
    end
    // the lowest cell takes the next bit of the word
    dig_shift[0] = {dig_keep[0], mag_q[VALUE_BITS-1]};
    for (int i = 1; i < NDIG; i++) begin
      dig_shift[i] = {dig_keep[i], dig_co[i-1]};
    end
  end

  // sequencer: convert, drop leading zeros, then emit prefix, sign, pad, digits
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mode_d      = mode_q;
    neg_d       = neg_q;
    zpad_d      = zpad_q;
    ptr_d       = ptr_q;
    w_d         = w_q;
    pad_d       = pad_q;
    mag_d       = mag_q;
    bcnt_d      = bcnt_q;
    dcnt_d      = dcnt_q;
    dig_d       = dig_q;
    in_ready_o  = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && mode_ok) begin
          mode_d = mode_e'(in_data_i.mode);
          neg_d  = val_neg;
          mag_d  = val_neg ? (~val_ext + 1'b1) : val_ext;
          dig_d  = '0;
          bcnt_d = BW'(VALUE_BITS - 1);
          if (in_data_i.mode == MODE_PTR) begin
            ptr_d  = 1'b1;
            zpad_d = 1'b1;
            w_d    = PW'(PTR_WIDTH);
          end else begin
            ptr_d  = 1'b0;
            zpad_d = in_data_i.zero_pad;
            w_d    = PW'(w_sat);
          end
          state_d = S_CONV;
        end
      end

      S_CONV: begin
        mag_d  = mag_q << 1;
        dig_d  = dig_shift;
        bcnt_d = bcnt_q - 1'b1;
        if (bcnt_q == '0) begin
          dcnt_d  = DW'(NDIG);
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // keep at least one digit so that zero prints as a single '0'
        if (dcnt_q > DW'(1) && dig_q[NDIG-1] == 4'd0) begin
          dig_d  = dig_q << 4;
          dcnt_d = dcnt_q - 1'b1;
        end else begin
          pad_d   = pad_calc;
          state_d = ptr_q ? S_PFX0 : S_SIGN1;
        end
      end

      S_PFX0: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{char_code: CHAR_ZERO, last_char: 1'b0};
          state_d     = S_PFXX;
        end
      end

      S_PFXX: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{char_code: CHAR_X, last_char: 1'b0};
          state_d     = S_SIGN1;
        end
      end

      S_SIGN1: begin
        // zero padding puts the minus ahead of the zeros
        if (neg_q && zpad_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d       = '{char_code: CHAR_MINUS, last_char: 1'b0};
            state_d     = S_PAD;
          end
        end else begin
          state_d = S_PAD;
        end
      end

      S_PAD: begin
        if (pad_q == '0) begin
          state_d = S_SIGN2;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{char_code: zpad_q ? CHAR_ZERO : CHAR_SPACE, last_char: 1'b0};
          pad_d       = pad_q - 1'b1;
        end
      end

      S_SIGN2: begin
        // space padding puts the minus right before the digits
        if (neg_q && !zpad_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d       = '{char_code: CHAR_MINUS, last_char: 1'b0};
            state_d     = S_DIGIT;
          end
        end else begin
          state_d = S_DIGIT;
        end
      end

      S_DIGIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{char_code: digit_char(dig_q[NDIG-1]),
                          last_char: (dcnt_q == DW'(1))};
          dig_d       = dig_q << 4;
          dcnt_d      = dcnt_q - 1'b1;
          if (dcnt_q == DW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    mode_q <= mode_d;
    neg_q  <= neg_d;
    zpad_q <= zpad_d;
    ptr_q  <= ptr_d;
    w_q    <= w_d;
    pad_q  <= pad_d;
    mag_q  <= mag_d;
    bcnt_q <= bcnt_d;
    dcnt_q <= dcnt_d;
    dig_q  <= dig_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a valid mode request always starts a conversion
  `I2A_ASSERT_NEXT(a_start_conv, in_valid_i && in_ready_o && mode_ok, state_q == S_CONV, "request not converted")
  // the digit count never runs out while digits remain to emit
  `I2A_ASSERT(a_dcnt_nonzero, (state_q != S_DIGIT) || (dcnt_q != '0), "digit count empty in digit phase")
  // the final digit is flagged as the end of the number
  `I2A_ASSERT_NEXT(a_last_flag, state_q == S_DIGIT && out_free && dcnt_q == DW'(1), out_valid_q && out_q.last_char && state_q == S_IDLE, "last digit not flagged")

endmodule
